// ===== src/sacl_pkg.sv =====
package sacl_pkg;

    // Field widths fixed by the transaction format
    localparam int ADDRESS_W  = 64;
    localparam int KIND_W     = 2;
    localparam int COUNT_W    = 32;
    localparam int SET_BITS_W = 4;
    localparam int OFF_BITS_W = 6;
    localparam int WAYS_CFG_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    // Masked set field before the modulo reduction: at most 15 set bits
    localparam int SET_RAW_W  = 15;

    // Access kinds
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_IFETCH = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED   = 2'd2;

    // Configuration reset values
    localparam logic [SET_BITS_W-1:0] RST_SET_BITS    = 4'd0;
    localparam logic [OFF_BITS_W-1:0] RST_OFFSET_BITS = 6'd4;
    localparam logic [WAYS_CFG_W-1:0] RST_WAYS_USED   = 3'd1;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [ADDRESS_W-1:0] address;
    } t_access;

    typedef struct packed {
        logic               was_hit;
        logic               was_miss;
        logic               was_eviction;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] miss_total;
        logic [COUNT_W-1:0] eviction_total;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic clr;
        logic load;
        logic split;
        logic red_hi;
        logic red_lo;
        logic issue;
        logic scan;
        logic fill;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic is_fetch;
        logic scan_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== src/set_assoc_cache_lru_sim_top.sv =====
// A data access is captured, split, reduced, issued, and its ways are then read one way per
// cycle on the RAM port (up to the ways in use, fewer on an early hit) before the fill.
// A new data access is taken only once the last is finished, though the output register lets
// it start while a result waits; an instruction fetch is taken and dropped with no result.
// Reset: synchronous, active low; totals and configuration return to defaults, then a
// clearing pass zeroes all MAX_SETS * WAYS tag RAM entries with the input not ready.
module set_assoc_cache_lru_sim_top
    import sacl_pkg::*;
#(
    parameter int MAX_SETS  = 256,
    parameter int WAYS      = 4,
    parameter int AGE_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  t_access               i_in_data,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output t_result               o_out_data,
    input  logic                  i_out_ready
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    sacl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    sacl_dp #(
        .MAX_SETS  (MAX_SETS),
        .WAYS      (WAYS),
        .AGE_WIDTH (AGE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== src/sacl_ram.sv =====
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sacl_ctrl.sv =====
module sacl_ctrl
    import sacl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SPLIT  = 4'd2;
    localparam logic [3:0] S_RED_HI = 4'd3;
    localparam logic [3:0] S_RED_LO = 4'd4;
    localparam logic [3:0] S_ISSUE  = 4'd5;
    localparam logic [3:0] S_SCAN   = 4'd6;
    localparam logic [3:0] S_FILL   = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Next state and command decode
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                // fetches are taken and dropped here
                if (i_in_valid && !i_sts.is_fetch) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SPLIT;
                end
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = S_RED_HI;
            end
            S_RED_HI: begin
                o_cmd.red_hi = 1'b1;
                n_state      = S_RED_LO;
            end
            S_RED_LO: begin
                o_cmd.red_lo = 1'b1;
                n_state      = S_ISSUE;
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/sacl_dp.sv =====
module sacl_dp
    import sacl_pkg::*;
#(
    parameter int MAX_SETS  = 256,
    parameter int WAYS      = 4,
    parameter int AGE_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_access               i_in_data,
    input  logic                  i_out_ready,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    output t_result               o_out_data
);

    localparam int SLOTS  = MAX_SETS * WAYS;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W  = $clog2(WAYS + 1);
    localparam int CMP_W  = (CNT_W > WAYS_CFG_W) ? CNT_W : WAYS_CFG_W;
    localparam int ENT_W  = 1 + ADDRESS_W + AGE_WIDTH;

    typedef struct packed {
        logic                 valid;
        logic [ADDRESS_W-1:0] tag;
        logic [AGE_WIDTH-1:0] age;
    } t_entry;

    // Configuration registers
    logic [SET_BITS_W-1:0] r_set_bits;
    logic [OFF_BITS_W-1:0] r_offset_bits;
    logic [WAYS_CFG_W-1:0] r_ways_used;

    // Access registers
    logic                 r_is_modify;
    logic [ADDRESS_W-1:0] r_addr;
    logic [SET_RAW_W-1:0] r_set_rem;
    logic [ADDRESS_W-1:0] r_tag;
    logic [WAY_W-1:0]     r_last_way;
    logic [ADDR_W-1:0]    r_base;

    // Scan registers
    logic [WAY_W-1:0]     r_way;
    logic                 r_hit;
    logic                 r_have_empty;
    logic [WAY_W-1:0]     r_empty_way;
    logic [AGE_WIDTH-1:0] r_best;
    logic [WAY_W-1:0]     r_victim;
    logic                 r_evict;

    // Totals, output and clearing pass
    logic [COUNT_W-1:0] r_hits;
    logic [COUNT_W-1:0] r_misses;
    logic [COUNT_W-1:0] r_evictions;
    logic               r_out_valid;
    t_result            r_out;
    logic [ADDR_W-1:0]  r_clr_idx;

    // Combinational signals
    logic [ADDRESS_W-1:0]  shifted;
    logic [SET_RAW_W-1:0]  set_mask;
    logic [6:0]            tag_shift;
    logic [ADDRESS_W-1:0]  tag_c;
    logic [CMP_W-1:0]      ways_ext;
    logic [CMP_W-1:0]      nways;
    logic [SET_W-1:0]      set_c;
    logic [ADDR_W-1:0]     base_c;
    t_entry                ent_q;
    logic [ENT_W-1:0]      rdata;
    logic                  tag_match;
    logic                  last_way;
    logic                  scan_done;
    logic [AGE_WIDTH-1:0]  aged;
    logic [WAY_W-1:0]      fill_way;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    t_entry                wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;

    // Restoring reduction modulo MAX_SETS over shift positions hi down to lo
    function automatic logic [SET_RAW_W-1:0] mod_steps(input logic [SET_RAW_W-1:0] v,
                                                       input int hi, input int lo);
        logic [SET_RAW_W-1:0] acc;
        logic [31:0]          sub;
        acc = v;
        for (int k = hi; k >= lo; k--) begin
            sub = 32'(MAX_SETS) << k;
            if (32'(acc) >= sub) begin
                acc = acc - SET_RAW_W'(sub);
            end
        end
        return acc;
    endfunction

    // Address split
    always_comb begin
        shifted   = r_addr >> r_offset_bits;
        set_mask  = (SET_RAW_W'(1) << r_set_bits) - SET_RAW_W'(1);
        tag_shift = 7'(r_set_bits) + 7'(r_offset_bits);
        tag_c     = (tag_shift >= 7'd64) ? '0 : (r_addr >> tag_shift[5:0]);
    end

    // Ways in use, clamped to one..WAYS
    always_comb begin
        ways_ext = CMP_W'(r_ways_used);
        if (ways_ext == '0) begin
            nways = CMP_W'(1);
        end else if (ways_ext > CMP_W'(WAYS)) begin
            nways = CMP_W'(WAYS);
        end else begin
            nways = ways_ext;
        end
    end

    assign set_c  = r_set_rem[SET_W-1:0];
    assign base_c = ADDR_W'(set_c) * ADDR_W'(WAYS);

    // Way evaluation on the registered read data
    assign ent_q     = t_entry'(rdata);
    assign tag_match = ent_q.valid && (ent_q.tag == r_tag);
    assign last_way  = (r_way == r_last_way);
    assign scan_done = tag_match || last_way;
    assign aged      = (ent_q.age == '1) ? ent_q.age : ent_q.age + AGE_WIDTH'(1);
    assign fill_way  = r_have_empty ? r_empty_way : r_victim;

    // Memory port control
    always_comb begin
        we    = 1'b0;
        waddr = r_base + ADDR_W'(r_way);
        wdata = '0;
        if (i_cmd.clr) begin
            we    = 1'b1;
            waddr = r_clr_idx;
        end else if (i_cmd.scan && ent_q.valid) begin
            we          = 1'b1;
            wdata.valid = 1'b1;
            wdata.tag   = tag_match ? r_tag : ent_q.tag;
            wdata.age   = tag_match ? '0 : aged;
        end else if (i_cmd.fill && !r_hit) begin
            we          = 1'b1;
            waddr       = r_base + ADDR_W'(fill_way);
            wdata.valid = 1'b1;
            wdata.tag   = r_tag;
        end
    end

    always_comb begin
        re    = i_cmd.issue || (i_cmd.scan && !scan_done);
        raddr = i_cmd.issue ? base_c : r_base + ADDR_W'(r_way) + ADDR_W'(1);
    end

    sacl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (ENT_W'(wdata)),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= RST_SET_BITS;
            r_offset_bits <= RST_OFFSET_BITS;
            r_ways_used   <= RST_WAYS_USED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SET_BITS:    r_set_bits    <= i_cfg_data[SET_BITS_W-1:0];
                CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[OFF_BITS_W-1:0];
                CFG_WAYS_USED:   r_ways_used   <= i_cfg_data[WAYS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Access capture, split and set reduction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_modify <= (i_in_data.kind == KIND_MODIFY);
            r_addr      <= i_in_data.address;
        end
        if (i_cmd.split) begin
            r_set_rem  <= shifted[SET_RAW_W-1:0] & set_mask;
            r_tag      <= tag_c;
            r_last_way <= WAY_W'(nways - CMP_W'(1));
        end else if (i_cmd.red_hi) begin
            r_set_rem <= mod_steps(r_set_rem, SET_RAW_W - 1, 7);
        end else if (i_cmd.red_lo) begin
            r_set_rem <= mod_steps(r_set_rem, 6, 0);
        end
        if (i_cmd.issue) begin
            r_base <= base_c;
        end
    end

    // Way scan: hit search, empty way and oldest way tracking
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_way        <= '0;
            r_hit        <= 1'b0;
            r_have_empty <= 1'b0;
            r_empty_way  <= '0;
            r_best       <= '0;
            r_victim     <= '0;
        end else if (i_cmd.scan) begin
            r_way <= r_way + WAY_W'(1);
            if (tag_match) begin
                r_hit <= 1'b1;
            end else if (ent_q.valid) begin
                if (aged >= r_best) begin
                    r_best   <= aged;
                    r_victim <= r_way;
                end
            end else begin
                r_have_empty <= 1'b1;
                r_empty_way  <= r_way;
            end
        end
        if (i_cmd.fill) begin
            r_evict <= !r_hit && !r_have_empty;
        end
    end

    // Clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr) begin
            r_clr_idx <= r_clr_idx + ADDR_W'(1);
        end
    end

    // Totals and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits      <= '0;
            r_misses    <= '0;
            r_evictions <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_hits      <= r_hits + COUNT_W'(r_is_modify) + COUNT_W'(r_hit);
            r_misses    <= r_misses + COUNT_W'(!r_hit);
            r_evictions <= r_evictions + COUNT_W'(r_evict);
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.was_hit        <= r_hit;
            r_out.was_miss       <= !r_hit;
            r_out.was_eviction   <= r_evict;
            r_out.hit_total      <= r_hits + COUNT_W'(r_is_modify) + COUNT_W'(r_hit);
            r_out.miss_total     <= r_misses + COUNT_W'(!r_hit);
            r_out.eviction_total <= r_evictions + COUNT_W'(r_evict);
        end
    end

    // Status back to the controller
    always_comb begin
        o_sts.clr_last  = (r_clr_idx == ADDR_W'(SLOTS - 1));
        o_sts.is_fetch  = (i_in_data.kind == KIND_IFETCH);
        o_sts.scan_done = scan_done;
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/sacl_chk.sv =====
module sacl_chk
    import sacl_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    o_in_ready,
    input logic    o_out_valid,
    input t_result o_out_data,
    input logic    i_out_ready
);

    // Reset empties the output and starts the clearing pass
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("output valid or input ready right after reset");

    // Every result is exactly one of hit or miss
    a_hit_xor_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.was_hit != o_out_data.was_miss))
        else $error("result is not exactly one of hit and miss");

    // An eviction only comes with a miss
    a_evict_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.was_eviction |-> o_out_data.was_miss)
        else $error("eviction reported without a miss");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

endmodule

bind set_assoc_cache_lru_sim_top sacl_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_ready (i_out_ready)
);
